FILE: hdl/qst_pkg.sv
package qst_pkg;

	// field widths and limits
	localparam int BYTE_W        = 8;
	localparam int LEN_W         = 20;
	localparam int MAX_RES       = 4;
	localparam int RES_IDX_W     = 2;
	localparam int LENGTH_LIMIT  = 1048576;
	localparam int QUEUE_DEPTH   = 4;
	localparam logic [LEN_W-1:0] MAX_LENGTH_RESET = 20'hFFFFF;

	// special characters
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;

	// result kinds
	typedef enum logic [1:0] {
		KIND_NAME  = 2'd0,
		KIND_VALUE = 2'd1,
		KIND_PAIR  = 2'd2,
		KIND_ERROR = 2'd3
	} kind_t;

	// parse phase, one-hot
	typedef enum logic [3:0] {
		PH_WAIT  = 4'b0001,
		PH_NAME  = 4'b0010,
		PH_VALUE = 4'b0100,
		PH_STOP  = 4'b1000
	} phase_t;

	// escape phase, one-hot
	typedef enum logic [2:0] {
		ESC_NONE  = 3'b001,
		ESC_PCT   = 3'b010,
		ESC_DIGIT = 3'b100
	} esc_t;

	// all results caused by one input word
	typedef struct packed {
		logic [MAX_RES-1:0][BYTE_W-1:0] bytes;
		logic [MAX_RES-1:0][1:0]        kinds;
		logic [RES_IDX_W-1:0]           last;
		logic                           eos;
	} bundle_t;

	function automatic logic is_hex(input logic [7:0] c);
		return ((c >= CH_0) && (c <= CH_9)) || ((c >= CH_UA) && (c <= CH_UF)) ||
			((c >= CH_LA) && (c <= CH_LF));
	endfunction

	// low nibble of '0'..'9' is the value; of 'a'..'f' / 'A'..'F' it is value - 9
	function automatic logic [3:0] hex_val(input logic [7:0] c);
		return (c <= CH_9) ? c[3:0] : (c[3:0] + 4'd9);
	endfunction

endpackage

FILE: hdl/qst_if.sv
interface qst_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_string;

	modport source (output valid, output in_byte, output end_of_string, input ready);
	modport sink (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface qst_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [1:0] kind;
	logic       string_done;
	logic       last_of_run;

	modport source (output valid, output out_byte, output kind, output string_done,
		output last_of_run, input ready);
	modport sink (input valid, input out_byte, input kind, input string_done,
		input last_of_run, output ready);
endinterface

FILE: hdl/qst_front.sv
module qst_front #(
	parameter int LENGTH_LIMIT = qst_pkg::LENGTH_LIMIT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      max_length_we,
	input  logic [qst_pkg::LEN_W-1:0] max_length_wdata,
	qst_in_if.sink                    raw,
	input  logic                      q_full,
	output logic                      push,
	output qst_pkg::bundle_t          push_data
);

	localparam int CW = $clog2(LENGTH_LIMIT);
	localparam logic [qst_pkg::LEN_W-1:0] LIM_MAX = qst_pkg::LEN_W'(LENGTH_LIMIT - 1);

	logic [qst_pkg::LEN_W-1:0] max_length_q;
	qst_pkg::phase_t           phase_q;
	qst_pkg::esc_t             esc_q;
	logic [7:0]                held_q;
	logic [CW-1:0]             count_q;

	qst_pkg::phase_t           ph_n;
	qst_pkg::esc_t             esc_n;
	logic [7:0]                held_n;
	logic [CW-1:0]             count_n;
	logic [2:0]                n_res;
	logic [qst_pkg::MAX_RES-1:0][7:0] rb;
	logic [qst_pkg::MAX_RES-1:0][1:0] rk;
	logic [qst_pkg::LEN_W-1:0] lim_full;
	logic [CW-1:0]             lim;
	logic                      accept;

	assign raw.ready = !q_full;
	assign accept    = raw.valid && raw.ready;

	// enforced length: min(max_length, LENGTH_LIMIT-1)
	assign lim_full = (max_length_q > LIM_MAX) ? LIM_MAX : max_length_q;
	assign lim      = lim_full[CW-1:0];

	// classify one word and list its results
	always_comb begin
		logic [7:0] b;
		logic       used;
		b       = raw.in_byte;
		used    = 1'b0;
		ph_n    = phase_q;
		esc_n   = esc_q;
		held_n  = held_q;
		count_n = count_q;
		n_res   = 3'd0;
		rb      = '0;
		rk      = '0;
		if (phase_q != qst_pkg::PH_STOP) begin
			if (count_q >= lim) begin
				rb[n_res[1:0]] = 8'h00; rk[n_res[1:0]] = qst_pkg::KIND_ERROR;
				n_res = n_res + 3'd1;
				ph_n   = qst_pkg::PH_STOP;
				esc_n  = qst_pkg::ESC_NONE;
				held_n = 8'h00;
			end else begin
				count_n = count_q + CW'(1);
				case (phase_q)
					qst_pkg::PH_WAIT: begin
						if (b == qst_pkg::CH_SPACE) begin
							ph_n = qst_pkg::PH_WAIT;
						end else if (b == qst_pkg::CH_EQ) begin
							rb[n_res[1:0]] = 8'h00; rk[n_res[1:0]] = qst_pkg::KIND_ERROR;
							n_res = n_res + 3'd1;
							ph_n = qst_pkg::PH_STOP;
						end else if (b == qst_pkg::CH_NUL) begin
							ph_n = qst_pkg::PH_STOP;
						end else begin
							rb[n_res[1:0]] = b; rk[n_res[1:0]] = qst_pkg::KIND_NAME;
							n_res = n_res + 3'd1;
							ph_n = qst_pkg::PH_NAME;
						end
					end
					qst_pkg::PH_NAME: begin
						if (b == qst_pkg::CH_SPACE) begin
							ph_n = qst_pkg::PH_NAME;
						end else if (b == qst_pkg::CH_EQ) begin
							ph_n = qst_pkg::PH_VALUE;
						end else if (b == qst_pkg::CH_NUL) begin
							rb[n_res[1:0]] = 8'h00; rk[n_res[1:0]] = qst_pkg::KIND_ERROR;
							n_res = n_res + 3'd1;
							ph_n = qst_pkg::PH_STOP;
						end else begin
							rb[n_res[1:0]] = b; rk[n_res[1:0]] = qst_pkg::KIND_NAME;
							n_res = n_res + 3'd1;
						end
					end
					qst_pkg::PH_VALUE: begin
						// pending escape first; a bad digit flushes it and falls through
						case (esc_q)
							qst_pkg::ESC_PCT: begin
								if (qst_pkg::is_hex(b)) begin
									held_n = b;
									esc_n  = qst_pkg::ESC_DIGIT;
									used   = 1'b1;
								end else begin
									rb[n_res[1:0]] = qst_pkg::CH_PCT;
									rk[n_res[1:0]] = qst_pkg::KIND_VALUE;
									n_res  = n_res + 3'd1;
									esc_n  = qst_pkg::ESC_NONE;
									held_n = 8'h00;
								end
							end
							qst_pkg::ESC_DIGIT: begin
								if (qst_pkg::is_hex(b)) begin
									rb[n_res[1:0]] = {qst_pkg::hex_val(held_q), qst_pkg::hex_val(b)};
									rk[n_res[1:0]] = qst_pkg::KIND_VALUE;
									n_res  = n_res + 3'd1;
									esc_n  = qst_pkg::ESC_NONE;
									held_n = 8'h00;
									used   = 1'b1;
								end else begin
									rb[n_res[1:0]] = qst_pkg::CH_PCT;
									rk[n_res[1:0]] = qst_pkg::KIND_VALUE;
									n_res = n_res + 3'd1;
									rb[n_res[1:0]] = held_q;
									rk[n_res[1:0]] = qst_pkg::KIND_VALUE;
									n_res  = n_res + 3'd1;
									esc_n  = qst_pkg::ESC_NONE;
									held_n = 8'h00;
								end
							end
							default: begin
								used = 1'b0;
							end
						endcase
						if (!used) begin
							if (b == qst_pkg::CH_AMP) begin
								rb[n_res[1:0]] = 8'h00; rk[n_res[1:0]] = qst_pkg::KIND_PAIR;
								n_res = n_res + 3'd1;
								ph_n = qst_pkg::PH_WAIT;
							end else if (b == qst_pkg::CH_NUL) begin
								rb[n_res[1:0]] = 8'h00; rk[n_res[1:0]] = qst_pkg::KIND_PAIR;
								n_res = n_res + 3'd1;
								ph_n = qst_pkg::PH_STOP;
							end else if (b == qst_pkg::CH_PCT) begin
								esc_n = qst_pkg::ESC_PCT;
							end else if (b == qst_pkg::CH_PLUS) begin
								rb[n_res[1:0]] = qst_pkg::CH_SPACE;
								rk[n_res[1:0]] = qst_pkg::KIND_VALUE;
								n_res = n_res + 3'd1;
							end else begin
								rb[n_res[1:0]] = b; rk[n_res[1:0]] = qst_pkg::KIND_VALUE;
								n_res = n_res + 3'd1;
							end
						end
					end
					default: begin
						ph_n = phase_q;
					end
				endcase
			end
		end
		// end of string: flush escape, close the pair, back to reset state
		if (raw.end_of_string) begin
			if (ph_n != qst_pkg::PH_STOP) begin
				if (esc_n == qst_pkg::ESC_PCT || esc_n == qst_pkg::ESC_DIGIT) begin
					rb[n_res[1:0]] = qst_pkg::CH_PCT; rk[n_res[1:0]] = qst_pkg::KIND_VALUE;
					n_res = n_res + 3'd1;
				end
				if (esc_n == qst_pkg::ESC_DIGIT) begin
					rb[n_res[1:0]] = held_n; rk[n_res[1:0]] = qst_pkg::KIND_VALUE;
					n_res = n_res + 3'd1;
				end
				rb[n_res[1:0]] = 8'h00; rk[n_res[1:0]] = qst_pkg::KIND_PAIR;
				n_res = n_res + 3'd1;
			end
			ph_n    = qst_pkg::PH_WAIT;
			esc_n   = qst_pkg::ESC_NONE;
			held_n  = 8'h00;
			count_n = '0;
		end
	end

	// word with results goes to the queue
	assign push            = accept && (n_res != 3'd0);
	assign push_data.bytes = rb;
	assign push_data.kinds = rk;
	assign push_data.last  = qst_pkg::RES_IDX_W'(n_res - 3'd1);
	assign push_data.eos   = raw.end_of_string;

	// length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q <= qst_pkg::MAX_LENGTH_RESET;
		end else if (max_length_we) begin
			max_length_q <= max_length_wdata;
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= qst_pkg::PH_WAIT;
			esc_q   <= qst_pkg::ESC_NONE;
			held_q  <= 8'h00;
			count_q <= '0;
		end else if (accept) begin
			phase_q <= ph_n;
			esc_q   <= esc_n;
			held_q  <= held_n;
			count_q <= count_n;
		end
	end

	// a stopped string makes no results
	a_stop_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && phase_q == qst_pkg::PH_STOP) |-> !push)
		else $error("result from stopped string");

	// an escape is only pending inside a value
	a_esc_in_value: assert property (@(posedge clk) disable iff (!arst_n)
		(esc_q != qst_pkg::ESC_NONE) |-> (phase_q == qst_pkg::PH_VALUE))
		else $error("escape pending outside value");

endmodule

FILE: hdl/qst_fifo.sv
module qst_fifo #(
	parameter int DEPTH = qst_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  qst_pkg::bundle_t push_data,
	output logic             full,
	input  logic             pop,
	output qst_pkg::bundle_t head,
	output logic             head_valid
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	qst_pkg::bundle_t mem_q [DEPTH];
	logic [AW-1:0]    wr_q;
	logic [AW-1:0]    rd_q;
	logic [CW-1:0]    cnt_q;

	assign full       = (cnt_q == CW'(DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: hdl/qst_back.sv
module qst_back (
	input  logic             clk,
	input  logic             arst_n,
	input  qst_pkg::bundle_t head,
	input  logic             head_valid,
	output logic             pop,
	qst_out_if.source        tok
);

	logic [qst_pkg::RES_IDX_W-1:0] sub_q;
	logic                          take;

	// walk the results of the head word one per cycle while tok.ready is high
	assign tok.valid       = head_valid;
	assign tok.out_byte    = head.bytes[sub_q];
	assign tok.kind        = head.kinds[sub_q];
	assign tok.string_done = head.eos;
	assign tok.last_of_run = (sub_q == head.last);

	assign take = tok.valid && tok.ready;
	assign pop  = take && (sub_q == head.last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q <= '0;
		end else if (pop) begin
			sub_q <= '0;
		end else if (take) begin
			sub_q <= sub_q + qst_pkg::RES_IDX_W'(1);
		end
	end

	// result index stays within the head word
	a_sub_bound: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> (sub_q <= head.last))
		else $error("result index past end of word");

	// each word starts at its first result
	a_sub_restart: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (sub_q == '0))
		else $error("next word not started at first result");

endmodule

FILE: hdl/query_string_tokenizer.sv
// A taken word's results are registered into the queue and offered from its head.
// Throughput: one input byte per cycle while the result queue has room; results
// leave one per cycle while tok.ready is high, and a word leaves after its last result.
// Queue of QUEUE_DEPTH words between the parser and the result serializer.
// Reset (arst_n low): parser state, queue and serializer clear; max_length = 1048575.
module query_string_tokenizer #(
	parameter int LENGTH_LIMIT = qst_pkg::LENGTH_LIMIT,
	parameter int QUEUE_DEPTH  = qst_pkg::QUEUE_DEPTH
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      max_length_we,
	input  logic [qst_pkg::LEN_W-1:0] max_length_wdata,
	qst_in_if.sink                    raw,
	qst_out_if.source                 tok
);

	logic             push;
	logic             pop;
	logic             q_full;
	logic             head_valid;
	qst_pkg::bundle_t push_data;
	qst_pkg::bundle_t head;

	qst_front #(
		.LENGTH_LIMIT(LENGTH_LIMIT)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.max_length_we    (max_length_we),
		.max_length_wdata (max_length_wdata),
		.raw              (raw),
		.q_full           (q_full),
		.push             (push),
		.push_data        (push_data)
	);

	qst_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.full       (q_full),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid)
	);

	qst_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.tok        (tok)
	);

endmodule
